// ===== hdl/dmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types, constants and helpers of the display matrix afterglow block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmd_pkg;

  localparam int DMD_MAX_ROWS     = 32;
  localparam int DMD_MAX_COLUMNS  = 32;
  localparam int DMD_COUNTER_BITS = 8;
  localparam int DMD_QUEUE_DEPTH  = 2;

  localparam int DATA_W = 32;
  localparam int ROWS_W = 6;
  localparam int TOP_W  = 5;
  localparam int DECAY_W = 8;
  localparam int INDEX_W = 5;

  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 6'd1;
  localparam logic [TOP_W-1:0]   TOP_RESET   = 5'd0;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd33;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_IN_USE = 2'd0,
    CFG_TOP_COLUMN  = 2'd1,
    CFG_DECAY_TICKS = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [ROWS_W-1:0]  rows_in_use;
    logic [TOP_W-1:0]   top_column;
    logic [DECAY_W-1:0] decay_ticks;
  } cfg_t;

  // one classified item, front to back
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] pattern;
    logic [DATA_W-1:0] row_select;
  } cmd_t;

  function automatic logic [TOP_W-1:0] eff_top(input logic [TOP_W-1:0] top,
                                               input int max_cols);
    logic [TOP_W-1:0] res;
    res = top;
    if (int'(top) >= max_cols) begin
      res = TOP_W'(max_cols - 1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dmd_ifs.sv =====
// ----------------------------------------------------------------------------
// dmd channel interfaces
// Valid/ready channels for incoming items and outgoing row results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] column_data;
  logic [31:0] row_select;

  modport source (output valid, output operation, output column_data,
                  output row_select, input ready);
  modport sink (input valid, input operation, input column_data,
                input row_select, output ready);
endinterface

interface dmd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index;
  logic [31:0] row_bits;
  logic        last_row;

  modport source (output valid, output row_index, output row_bits,
                  output last_row, input ready);
  modport sink (input valid, input row_index, input row_bits,
                input last_row, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmd_ram.sv =====
// ----------------------------------------------------------------------------
// dmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dmd_front.sv =====
// ----------------------------------------------------------------------------
// dmd_front
// Accepts items and classifies them into commands for the row engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_front
  import dmd_pkg::*;
#(
  parameter int MAX_COLUMNS = DMD_MAX_COLUMNS
) (
  dmd_in_if.sink                 in_ch,
  input  wire logic [TOP_W-1:0]  top_column,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic [TOP_W-1:0]  top_eff;
  logic [DATA_W-1:0] top_bit;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign top_eff = eff_top(top_column, MAX_COLUMNS);
  assign top_bit = DATA_W'(1) << top_eff;

  always_comb begin
    q_cmd.op         = op_t'(in_ch.operation);
    // data columns below the top plus the always-on top column
    q_cmd.pattern    = (in_ch.column_data & (top_bit - DATA_W'(1))) | top_bit;
    q_cmd.row_select = in_ch.row_select;
  end

endmodule

`default_nettype wire

// ===== hdl/dmd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dmd_cmd_fifo
// Short command queue between the front and the row engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_cmd_fifo
  import dmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  localparam int PTR_W = DMD_QUEUE_DEPTH > 1 ? $clog2(DMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(DMD_QUEUE_DEPTH + 1);

  cmd_t             mem_r [DMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == CNT_W'(DMD_QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DMD_QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DMD_QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dmd_back.sv =====
// ----------------------------------------------------------------------------
// dmd_back
// Row engine: one row of segment counters per cycle unless stalled, change detection and
// result output with one result held back to mark the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_back
  import dmd_pkg::*;
#(
  parameter int MAX_ROWS     = DMD_MAX_ROWS,
  parameter int MAX_COLUMNS  = DMD_MAX_COLUMNS,
  parameter int COUNTER_BITS = DMD_COUNTER_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_not_empty,
  input  wire cmd_t  q_head,
  output logic       q_pop,
  dmd_out_if.source  out_ch
);

  localparam int ROW_W = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int ISS_W = $clog2(MAX_ROWS + 1);
  localparam int LINE_W = MAX_COLUMNS * COUNTER_BITS;

  back_state_t               state_r, state_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic [ISS_W-1:0]          iss_r, iss_nxt;
  logic                      bv_r, bv_nxt;
  logic [ROW_W-1:0]          brow_r, brow_nxt;
  logic                      bcv_r, bcv_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic [ROW_W-1:0]          pend_row_r, pend_row_nxt;
  logic [DATA_W-1:0]         pend_bits_r, pend_bits_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]        out_row_r, out_row_nxt;
  logic [DATA_W-1:0]         out_bits_r, out_bits_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [MAX_COLUMNS-1:0]    powered_r  [MAX_ROWS];
  logic [DATA_W-1:0]         reported_r [MAX_ROWS];
  logic                      cnt_vld_r  [MAX_ROWS];

  logic [ROWS_W-1:0]         rows_eff;
  logic [TOP_W-1:0]          top_eff;
  logic [COUNTER_BITS-1:0]   decay;
  logic                      iss_more;
  logic                      out_free;
  logic [LINE_W-1:0]         rd_line;
  logic [LINE_W-1:0]         new_line;
  logic [MAX_COLUMNS-1:0]    pw;
  logic [DATA_W-1:0]         active;
  logic                      changed;
  logic                      stall;
  logic                      advance;
  logic                      rd_en;
  logic                      row_done;

  assign rows_eff = (cfg.rows_in_use > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                          : cfg.rows_in_use;
  assign top_eff  = eff_top(cfg.top_column, MAX_COLUMNS);
  assign decay    = COUNTER_BITS'(cfg.decay_ticks);
  assign iss_more = ROWS_W'(iss_r) < rows_eff;
  assign out_free = !out_valid_r || out_ch.ready;

  dmd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ROWS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (row_done),
    .waddr (brow_r),
    .wdata (new_line),
    .re    (rd_en),
    .raddr (ROW_W'(iss_r)),
    .rdata (rd_line)
  );

  // powered pattern of the row in work: fresh on a write, latched on a tick
  always_comb begin
    if (cmd_r.op == OP_WRITE) begin
      pw = cmd_r.row_select[brow_r] ? MAX_COLUMNS'(cmd_r.pattern) : '0;
    end else begin
      pw = powered_r[brow_r];
    end
  end

  // decay, reload and visibility of one row of counters
  always_comb begin
    logic [COUNTER_BITS-1:0] c;
    new_line = '0;
    active   = '0;
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      c = bcv_r ? rd_line[x*COUNTER_BITS +: COUNTER_BITS] : '0;
      if (TOP_W'(x) <= top_eff) begin
        if (cmd_r.op == OP_TICK && c != '0) begin
          c = c - COUNTER_BITS'(1);
        end
        if (pw[x]) begin
          c = decay;
        end
        active[x] = c != '0;
      end
      new_line[x*COUNTER_BITS +: COUNTER_BITS] = c;
    end
  end

  assign changed  = active != reported_r[brow_r];
  assign stall    = state_r == ST_RUN && bv_r && changed && pend_valid_r && !out_free;
  assign advance  = !stall;
  assign rd_en    = state_r == ST_RUN && advance && iss_more;
  assign row_done = state_r == ST_RUN && advance && bv_r;
  assign q_pop    = state_r == ST_IDLE && q_not_empty;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    iss_nxt        = iss_r;
    bv_nxt         = bv_r;
    brow_nxt       = brow_r;
    bcv_nxt        = bcv_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_bits_nxt  = pend_bits_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_row_nxt    = out_row_r;
    out_bits_nxt   = out_bits_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          cmd_nxt   = q_head;
          iss_nxt   = '0;
          bv_nxt    = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (rd_en) begin
            iss_nxt  = iss_r + ISS_W'(1);
            bv_nxt   = 1'b1;
            brow_nxt = ROW_W'(iss_r);
            bcv_nxt  = cnt_vld_r[ROW_W'(iss_r)];
          end else begin
            bv_nxt    = 1'b0;
            state_nxt = ST_FLUSH;
          end
          if (bv_r && changed) begin
            // a newer change means the held one is not the last
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = INDEX_W'(pend_row_r);
              out_bits_nxt  = pend_bits_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_row_nxt   = brow_r;
            pend_bits_nxt  = active;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_row_nxt    = INDEX_W'(pend_row_r);
          out_bits_nxt   = pend_bits_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bv_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      iss_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      bv_r         <= bv_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      iss_r        <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    brow_r      <= brow_nxt;
    bcv_r       <= bcv_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_bits_r <= pend_bits_nxt;
    out_row_r   <= out_row_nxt;
    out_bits_r  <= out_bits_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < MAX_ROWS; y++) begin
        powered_r[y]  <= '0;
        reported_r[y] <= '1;
        cnt_vld_r[y]  <= 1'b0;
      end
    end else if (row_done) begin
      powered_r[brow_r]  <= pw;
      reported_r[brow_r] <= active;
      cnt_vld_r[brow_r]  <= 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = out_row_r;
  assign out_ch.row_bits  = out_bits_r;
  assign out_ch.last_row  = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("held result left over in idle");

  a_stage_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    bv_r |-> state_r == ST_RUN)
    else $error("row in work outside of run");

  a_stall_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> bv_r && $stable(brow_r))
    else $error("row in work moved during stall");

  a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
    row_done && rd_en |-> brow_r != ROW_W'(iss_r))
    else $error("counter row read while being written");

endmodule

`default_nettype wire

// ===== hdl/display_matrix_decay_top.sv =====
// ----------------------------------------------------------------------------
// display_matrix_decay_top
// Afterglow model of a strobed display matrix: per-segment decay counters,
// one result word per row whose visible bits changed.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     operation, column_data, row_select
//   out_ch   out  valid/ready     row_index, row_bits, last_row
//   cfg_*    in   cfg_we only     cfg_index, cfg_data (8 bits)
//
// The row engine handles one row of counters a cycle, unless stalled, through
// the single read port of the counter RAM.
// Reset is synchronous; all rows are read as cleared until first written.
// A stalled output holds the engine when a changed row meets both a held row
// and a busy output word, and at the end of an item until the held row leaves;
// the two-entry queue keeps taking items meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module display_matrix_decay_top
  import dmd_pkg::*;
#(
  parameter int MAX_ROWS     = DMD_MAX_ROWS,
  parameter int MAX_COLUMNS  = DMD_MAX_COLUMNS,
  parameter int COUNTER_BITS = DMD_COUNTER_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  dmd_in_if.sink           in_ch,
  dmd_out_if.source        out_ch
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_not_empty;
  cmd_t q_cmd, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: cfg_nxt.rows_in_use = ROWS_W'(cfg_data);
        CFG_TOP_COLUMN:  cfg_nxt.top_column  = TOP_W'(cfg_data);
        CFG_DECAY_TICKS: cfg_nxt.decay_ticks = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use <= ROWS_RESET;
      cfg_r.top_column  <= TOP_RESET;
      cfg_r.decay_ticks <= DECAY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dmd_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .in_ch      (in_ch),
    .top_column (cfg_r.top_column),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  dmd_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  dmd_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLUMNS  (MAX_COLUMNS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ===== test/display_matrix_decay_top_tb.sv =====
// ----------------------------------------------------------------------------
// display_matrix_decay_top_tb
// Drives matrix writes and decay ticks into the afterglow block under several
// register settings and compares each emitted row word against a software
// model of the powered rows, segment counters and last-reported rows.
// ----------------------------------------------------------------------------

module display_matrix_decay_top_tb
  import dmd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0] row;
    logic [DATA_W-1:0]  bits;
    logic               last;
  } row_word_t;

  // model of the afterglow state plus the queue of row words still due
  class row_change_board;
    logic [ROWS_W-1:0]  rows_in_use;
    logic [TOP_W-1:0]   top_col;
    logic [DECAY_W-1:0] decay_len;
    logic [DATA_W-1:0]  powered [DMD_MAX_ROWS];
    logic [DECAY_W-1:0] glow [DMD_MAX_ROWS][DMD_MAX_COLUMNS];
    logic [DATA_W-1:0]  shown [DMD_MAX_ROWS];
    row_word_t          due_rows [$];
    int                 errors;

    function new();
      rows_in_use = ROWS_RESET;
      top_col     = TOP_RESET;
      decay_len   = DECAY_RESET;
      for (int y = 0; y < DMD_MAX_ROWS; y++) begin
        powered[y] = '0;
        shown[y]   = '1;
        for (int x = 0; x < DMD_MAX_COLUMNS; x++) begin
          glow[y][x] = '0;
        end
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] val);
      case (idx)
        CFG_ROWS_IN_USE: rows_in_use = val[ROWS_W-1:0];
        CFG_TOP_COLUMN:  top_col = val[TOP_W-1:0];
        CFG_DECAY_TICKS: decay_len = val[DECAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(op_t op, logic [DATA_W-1:0] cols, logic [DATA_W-1:0] sel);
      int rows;
      int top;
      int n;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] lit [DMD_MAX_ROWS];
      rows = (int'(rows_in_use) > DMD_MAX_ROWS) ? DMD_MAX_ROWS : int'(rows_in_use);
      top  = (int'(top_col) >= DMD_MAX_COLUMNS) ? DMD_MAX_COLUMNS - 1 : int'(top_col);
      mask = (32'd1 << top) - 32'd1;
      if (op == OP_WRITE) begin
        for (int y = 0; y < rows; y++) begin
          powered[y] = sel[y] ? ((cols & mask) | (32'd1 << top)) : '0;
        end
      end else begin
        for (int y = 0; y < rows; y++) begin
          for (int x = 0; x <= top; x++) begin
            if (glow[y][x] != '0) begin
              glow[y][x] = glow[y][x] - 8'd1;
            end
          end
        end
      end
      // reload powered segments, then a segment is visible while its counter runs
      for (int y = 0; y < rows; y++) begin
        lit[y] = '0;
        for (int x = 0; x <= top; x++) begin
          if (powered[y][x]) begin
            glow[y][x] = decay_len;
          end
          if (glow[y][x] != '0) begin
            lit[y][x] = 1'b1;
          end
        end
      end
      n = 0;
      for (int y = 0; y < rows; y++) begin
        if (shown[y] != lit[y]) begin
          due_rows.push_back('{row: INDEX_W'(y), bits: lit[y], last: 1'b0});
          n++;
        end
        shown[y] = lit[y];
      end
      if (n > 0) begin
        due_rows[due_rows.size()-1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("error: %s", msg);
      end
    endtask

    task check_row(logic [INDEX_W-1:0] row, logic [DATA_W-1:0] bits, logic last);
      row_word_t want;
      if (due_rows.size() == 0) begin
        report($sformatf("unexpected word row %0d bits %h last %b", row, bits, last));
        return;
      end
      want = due_rows.pop_front();
      if (row !== want.row) begin
        report($sformatf("row index %0d, expected %0d", row, want.row));
      end
      if (bits !== want.bits) begin
        report($sformatf("row %0d bits %h, expected %h", want.row, bits, want.bits));
      end
      if (last !== want.last) begin
        report($sformatf("row %0d last %b, expected %b", want.row, last, want.last));
      end
    endtask

    function int waiting();
      return due_rows.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;
  bit                calm = 1'b0;
  int                guard;
  row_change_board   sb = new();

  dmd_in_if  in_ch ();
  dmd_out_if out_ch ();

  display_matrix_decay_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_row(out_ch.row_index, out_ch.row_bits, out_ch.last_row);
    end
  end

  function automatic bit gap_now();
    return !calm && ($urandom_range(0, 99) < 15);
  endfunction

  task send_item(op_t op, logic [DATA_W-1:0] cols, logic [DATA_W-1:0] sel);
    while (gap_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.column_data <= cols;
    in_ch.row_select  <= sel;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, cols, sel);
  endtask

  task random_item();
    op_t               op;
    logic [DATA_W-1:0] cols;
    logic [DATA_W-1:0] sel;
    int                pick;
    op   = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_WRITE;
    cols = $urandom;
    pick = $urandom_range(0, 9);
    sel  = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
    send_item(op, cols, sel);
  endtask

  // drain every due word, then cover items still queued that emit nothing
  task settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
    repeat (120) @(posedge clk);
  endtask

  task write_reg(cfg_index_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task apply_setting(int rows, int top, int decay);
    settle();
    write_reg(CFG_ROWS_IN_USE, 8'(rows));
    write_reg(CFG_TOP_COLUMN, 8'(top));
    write_reg(CFG_DECAY_TICKS, 8'(decay));
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_ROWS_IN_USE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_WRITE;
    in_ch.column_data = '0;
    in_ch.row_select  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: one row, top column 0
    send_item(OP_WRITE, '1, '1);
    send_item(OP_TICK, '0, '0);
    send_item(OP_WRITE, '0, '0);

    // full matrix, shortest nonzero decay: everything lights then drops at one tick
    apply_setting(32, 31, 1);
    send_item(OP_WRITE, '1, '1);
    send_item(OP_WRITE, '0, '0);
    send_item(OP_TICK, '1, '1);
    send_item(OP_WRITE, 32'h5555_5555, 32'haaaa_aaaa);
    send_item(OP_TICK, 32'h0, 32'h0);
    send_item(OP_TICK, 32'h0, 32'h0);

    // zero decay length keeps powered segments dark
    apply_setting(32, 31, 0);
    send_item(OP_WRITE, '1, '1);

    // no rows scanned
    apply_setting(0, 31, 5);
    send_item(OP_WRITE, '1, '1);
    send_item(OP_TICK, '0, '0);

    // more rows than the matrix has
    apply_setting(40, 0, 2);
    send_item(OP_WRITE, 32'h0000_ffff, 32'h8000_0001);
    send_item(OP_TICK, '0, '0);

    // longest decay, columns above the top ignored
    apply_setting(32, 15, 255);
    send_item(OP_WRITE, 32'h1234_5678, 32'hf0f0_f0f0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_WRITE, 32'hffff_0000, 32'h0000_0000);
    send_item(OP_TICK, '1, '1);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: apply_setting(32, 31, 3);
        1: apply_setting($urandom_range(1, 32), $urandom_range(0, 31), $urandom_range(1, 4));
        2: apply_setting(63, 31, 255);
        3: apply_setting($urandom_range(1, 32), $urandom_range(0, 31), 2);
        4: apply_setting(32, 0, 1);
        5: apply_setting($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 255));
        default: apply_setting(32, 31, 2);
      endcase
      calm = (p == 3);
      for (int i = 0; i < 40; i++) begin
        random_item();
      end
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.waiting() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
    if (sb.waiting() != 0) begin
      sb.report($sformatf("%0d row words never arrived", sb.waiting()));
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
